@@ design/phdc_pkg.sv @@
// Shared types for the packet hash duplicate cache.
package phdc_pkg;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear;
      logic remove;
      logic write;
   } cell_ctl_type;

endpackage

@@ design/phdc_cell.sv @@
// One slot of the hash table: stored hash, valid bit and one step of the scan chain.
module phdc_cell #(
   parameter int KEY_BITS = 64,
   parameter int PTR_W    = 5,
   parameter int INDEX    = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  phdc_pkg::cell_ctl_type ctl,
   input  logic [KEY_BITS-1:0]   key,
   input  logic [PTR_W-1:0]      wr_ptr,
   input  logic                  turn_in,
   input  logic                  hit_in,
   output logic                  turn_out,
   output logic                  hit_out
);

   logic                valid_ff, valid_in;
   logic [KEY_BITS-1:0] hash_ff, hash_in;
   logic                turn_ff, hit_ff;
   logic                match;
   logic                wr_sel;

   assign match    = turn_ff & valid_ff & (hash_ff == key);
   assign wr_sel   = ctl.write & (wr_ptr == PTR_W'(INDEX));
   assign hit_out  = hit_ff | match;
   assign turn_out = turn_ff;

   always_comb begin
      valid_in = valid_ff;
      hash_in  = hash_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (wr_sel) begin
         valid_in = 1'b1;
         hash_in  = key;
      end else if (ctl.remove && match) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         turn_ff  <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         turn_ff  <= turn_in;
         hit_ff   <= turn_in & hit_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
   end

endmodule

@@ design/packet_hash_dedup_cache_core.sv @@
// Top level of the packet hash duplicate cache: control, write pointer and the chain of slots.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_opcode, req_key_hash
//   rsp      out        rsp_valid/rsp_ready  rsp_success
//
// A lookup, insert or remove beat sends a scan marker that walks the chain of slot
// cells one cell per cycle; the done state then loads the result into the rsp side.
// A clear beat goes straight to the done state. After reset the table is empty and a beat is
// taken at once. A new beat is taken while a result still waits on a stalled rsp side;
// its result waits in turn until the previous one is taken.
module packet_hash_dedup_cache_core #(
   parameter int SLOT_COUNT = 32,
   parameter int HASH_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [63:0] req_key_hash,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_success
);

   localparam int KEY_BITS = 8 * HASH_BYTES;
   localparam int PTR_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   phdc_pkg::state_type    state_ff, state_in;
   phdc_pkg::op_type       op_ff, op_in, req_op;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [PTR_W-1:0]       ptr_ff, ptr_in;
   logic                   res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_success_ff, rsp_success_in;
   logic                   accept, start, rsp_load;
   logic                   scan_done, final_hit;
   phdc_pkg::cell_ctl_type ctl;
   logic [SLOT_COUNT:0]    turn_chain;
   logic [SLOT_COUNT:0]    hit_chain;

   assign req_op      = phdc_pkg::op_type'(req_opcode);
   assign accept      = req_valid & req_ready;
   assign scan_done   = turn_chain[SLOT_COUNT];
   assign final_hit   = hit_chain[SLOT_COUNT];
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_success = rsp_success_ff;

   assign turn_chain[0] = start;
   assign hit_chain[0]  = 1'b0;

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_slot
      phdc_cell #(
         .KEY_BITS (KEY_BITS),
         .PTR_W    (PTR_W),
         .INDEX    (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .key      (key_ff),
         .wr_ptr   (ptr_ff),
         .turn_in  (turn_chain[i]),
         .hit_in   (hit_chain[i]),
         .turn_out (turn_chain[i+1]),
         .hit_out  (hit_chain[i+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         phdc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_op == phdc_pkg::OP_CLEAR) ? phdc_pkg::ST_DONE
                                                         : phdc_pkg::ST_SCAN;
            end
         end
         phdc_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = phdc_pkg::ST_DONE;
            end
         end
         phdc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = phdc_pkg::ST_IDLE;
            end
         end
         default: state_in = phdc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      start      = 1'b0;
      rsp_load   = 1'b0;
      ctl.clear  = 1'b0;
      ctl.remove = 1'b0;
      ctl.write  = 1'b0;
      unique case (state_ff)
         phdc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            start     = req_valid & (req_op != phdc_pkg::OP_CLEAR);
            ctl.clear = req_valid & (req_op == phdc_pkg::OP_CLEAR);
         end
         phdc_pkg::ST_SCAN: begin
            ctl.remove = (op_ff == phdc_pkg::OP_REMOVE);
            ctl.write  = scan_done & (op_ff == phdc_pkg::OP_INSERT) & ~final_hit;
         end
         phdc_pkg::ST_DONE: begin
            rsp_load = ~rsp_valid_ff | rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      op_in          = op_ff;
      key_in         = key_ff;
      ptr_in         = ptr_ff;
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_success_in = rsp_success_ff;
      if (accept) begin
         op_in  = req_op;
         key_in = req_key_hash[KEY_BITS-1:0];
         res_in = 1'b0;
      end
      if (ctl.clear) begin
         ptr_in = '0;
      end
      if (ctl.write) begin
         ptr_in = (ptr_ff == PTR_W'(SLOT_COUNT - 1)) ? '0 : ptr_ff + 1'b1;
      end
      if (state_ff == phdc_pkg::ST_SCAN && scan_done) begin
         res_in = (op_ff == phdc_pkg::OP_INSERT) ? ~final_hit : final_hit;
      end
      if (rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_success_in = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= phdc_pkg::ST_IDLE;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         op_ff        <= phdc_pkg::OP_LOOKUP;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff        <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      res_ff         <= res_in;
      rsp_success_ff <= rsp_success_in;
   end

   // Only one scan marker is ever in flight along the chain.
   a_one_marker: assert property (@(posedge clock) disable iff (reset)
      $onehot0(turn_chain[SLOT_COUNT:1]))
      else $error("more than one scan marker in the slot chain");

   // The marker leaves the chain only while a scan is running.
   a_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_done |-> state_ff == phdc_pkg::ST_SCAN)
      else $error("scan finished outside the scan state");

   // Only an insert moves the write pointer during a scan.
   a_ptr_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == phdc_pkg::ST_SCAN && op_ff != phdc_pkg::OP_INSERT) |=> $stable(ptr_ff))
      else $error("write pointer moved on a lookup or remove");

   // A clear beat returns the write pointer to the first slot.
   a_clear_ptr: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |=> ptr_ff == '0)
      else $error("write pointer not reset by clear");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the packet hash duplicate cache core.
`timescale 1ns / 100ps

module tb_top;

   localparam int  CLK_PERIOD   = 20;
   localparam int  SLOT_COUNT   = 32;
   localparam int  RANDOM_BEATS = 1150;
   localparam int  POOL_SIZE    = 48;
   localparam int  SETTLE_WAIT  = 40;
   localparam int  CYCLE_LIMIT  = 1000000;

   typedef struct {
      phdc_pkg::op_type opcode;
      logic [63:0]      key_hash;
      bit               drain_first;
   } hash_request_type;

   typedef struct {
      phdc_pkg::op_type opcode;
      logic [63:0]      key_hash;
      logic             success;
   } hash_outcome_type;

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode   = phdc_pkg::OP_LOOKUP;
   logic [63:0] req_key_hash = '0;
   logic        rsp_valid;
   logic        rsp_ready    = 1'b0;
   logic        rsp_success;

   hash_request_type pending_requests[$];
   hash_outcome_type expected_outcomes[$];

   logic [63:0] cache_hash  [SLOT_COUNT];
   bit          cache_valid [SLOT_COUNT];
   int          cache_wr_ptr;

   bit          req_beat_taken = 1'b0;
   int          burst_left     = 0;
   int          gap_left       = 0;
   int          ready_hold     = 0;
   int          mismatch_count = 0;
   int          cycle_count    = 0;

   packet_hash_dedup_cache_core i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_opcode   (req_opcode),
      .req_key_hash (req_key_hash),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_success  (rsp_success)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic int find_cached_slot(logic [63:0] key);
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (cache_valid[i] && cache_hash[i] == key) begin
            return i;
         end
      end
      return SLOT_COUNT;
   endfunction

   function automatic logic apply_cache_op(phdc_pkg::op_type opcode, logic [63:0] key);
      int hit;
      logic success;
      success = 1'b0;
      hit = find_cached_slot(key);
      case (opcode)
         phdc_pkg::OP_LOOKUP: begin
            success = (hit < SLOT_COUNT);
         end
         phdc_pkg::OP_INSERT: begin
            if (hit == SLOT_COUNT) begin
               cache_hash[cache_wr_ptr]  = key;
               cache_valid[cache_wr_ptr] = 1'b1;
               cache_wr_ptr = (cache_wr_ptr + 1) % SLOT_COUNT;
               success = 1'b1;
            end
         end
         phdc_pkg::OP_REMOVE: begin
            if (hit < SLOT_COUNT) begin
               cache_hash[hit]  = '0;
               cache_valid[hit] = 1'b0;
               success = 1'b1;
            end
         end
         default: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               cache_hash[i]  = '0;
               cache_valid[i] = 1'b0;
            end
            cache_wr_ptr = 0;
         end
      endcase
      return success;
   endfunction

   task automatic queue_request(phdc_pkg::op_type opcode, logic [63:0] key, bit drain_first);
      hash_request_type beat;
      beat.opcode      = opcode;
      beat.key_hash    = key;
      beat.drain_first = drain_first;
      pending_requests.push_back(beat);
   endtask

   // Sender: bursts of beats separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beat_taken) begin
         if (gap_left > 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_requests.size() == 0 ||
                      (pending_requests[0].drain_first && expected_outcomes.size() != 0)) begin
            req_valid <= 1'b0;
         end else begin
            hash_request_type beat;
            beat = pending_requests.pop_front();
            req_valid    <= 1'b1;
            req_opcode   <= beat.opcode;
            req_key_hash <= beat.key_hash;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 60);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // Receiver: long ready stretches, random flicker and long stalls.
   always @(negedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         int pick;
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            rsp_ready  <= 1'b1;
            ready_hold <= $urandom_range(0, 200);
         end else if (pick < 8) begin
            rsp_ready  <= 1'($urandom_range(0, 1));
            ready_hold <= $urandom_range(0, 3);
         end else begin
            rsp_ready  <= 1'b0;
            ready_hold <= $urandom_range(5, 60);
         end
      end
   end

   // Monitor: predicts each accepted request beat and checks each response beat.
   always @(posedge clock) begin : monitor
      hash_outcome_type outcome;
      req_beat_taken <= req_valid && req_ready && !reset;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_outcomes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Unexpected response beat: success %0b", rsp_success);
               end
            end else begin
               outcome = expected_outcomes.pop_front();
               if (rsp_success !== outcome.success) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("Mismatch on %s key %h: expected success %0b, got %0b",
                              outcome.opcode.name(), outcome.key_hash, outcome.success,
                              rsp_success);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            outcome.opcode   = phdc_pkg::op_type'(req_opcode);
            outcome.key_hash = req_key_hash;
            outcome.success  = apply_cache_op(phdc_pkg::op_type'(req_opcode), req_key_hash);
            expected_outcomes.push_back(outcome);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("packet_hash_dedup_cache_core verification failed");
         $finish;
      end
   end

   initial begin
      logic [63:0]      key_pool [POOL_SIZE];
      logic [63:0]      key;
      phdc_pkg::op_type opcode;
      int               pick;

      for (int i = 0; i < SLOT_COUNT; i++) begin
         cache_hash[i]  = '0;
         cache_valid[i] = 1'b0;
      end
      cache_wr_ptr = 0;

      queue_request(phdc_pkg::OP_LOOKUP, 64'h0, 1'b0);
      queue_request(phdc_pkg::OP_REMOVE, 64'h0, 1'b0);
      queue_request(phdc_pkg::OP_INSERT, 64'h0, 1'b0);
      queue_request(phdc_pkg::OP_INSERT, '1, 1'b0);
      queue_request(phdc_pkg::OP_INSERT, 64'h0, 1'b0);
      queue_request(phdc_pkg::OP_LOOKUP, '1, 1'b0);
      queue_request(phdc_pkg::OP_LOOKUP, 64'h0, 1'b0);
      queue_request(phdc_pkg::OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      queue_request(phdc_pkg::OP_INSERT, 64'h5555_5555_5555_5555, 1'b0);
      queue_request(phdc_pkg::OP_REMOVE, '1, 1'b0);
      queue_request(phdc_pkg::OP_REMOVE, '1, 1'b0);
      queue_request(phdc_pkg::OP_LOOKUP, '1, 1'b0);
      queue_request(phdc_pkg::OP_INSERT, '1, 1'b0);
      queue_request(phdc_pkg::OP_CLEAR, {$urandom, $urandom}, 1'b0);
      queue_request(phdc_pkg::OP_LOOKUP, 64'h0, 1'b0);
      queue_request(phdc_pkg::OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      queue_request(phdc_pkg::OP_INSERT, 64'h8000_0000_0000_0001, 1'b0);
      queue_request(phdc_pkg::OP_REMOVE, 64'h8000_0000_0000_0001, 1'b0);
      queue_request(phdc_pkg::OP_INSERT, 64'h8000_0000_0000_0001, 1'b0);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 250 == 0) begin
            for (int i = 0; i < POOL_SIZE; i++) begin
               key_pool[i] = {$urandom, $urandom};
            end
         end
         pick = $urandom_range(0, 99);
         if (pick < 1) begin
            opcode = phdc_pkg::OP_CLEAR;
         end else if (pick < 45) begin
            opcode = phdc_pkg::OP_INSERT;
         end else if (pick < 75) begin
            opcode = phdc_pkg::OP_LOOKUP;
         end else begin
            opcode = phdc_pkg::OP_REMOVE;
         end
         if ($urandom_range(0, 6) == 0) begin
            key = {$urandom, $urandom};
         end else begin
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         end
         queue_request(opcode, key, n == RANDOM_BEATS / 2);
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do begin
         @(posedge clock);
      end while (pending_requests.size() != 0 || req_valid || expected_outcomes.size() != 0);
      repeat (SETTLE_WAIT) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("packet_hash_dedup_cache_core verification clean");
      end else begin
         $display("packet_hash_dedup_cache_core verification failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/phdc_pkg.sv
design/phdc_cell.sv
design/packet_hash_dedup_cache_core.sv
sim/tb_top.sv
